@@ hw/rtl/se3x_pkg.sv @@
// ----------------------------------------------------------------------------
// se3x_pkg
// Shared types, constants and fixed-point helpers of the SE(3) exponential map.
// ----------------------------------------------------------------------------
package se3x_pkg;

  localparam int ISQ_STEPS = 32;
  localparam int ISQ_LAT   = ISQ_STEPS + 1;
  localparam int DIV_STEPS = 31;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int SC_STEPS  = 6;
  localparam int SIN_TERMS = 5;
  localparam int SC_N      = 3 * SC_STEPS;
  localparam int K_MAX     = 10;

  localparam logic [30:0] ONE_Q30     = 31'd1 << 30;
  localparam logic [35:0] HALF_PI     = 36'd1686629713;
  localparam logic [35:0] HALF_PI_LOW = HALF_PI / 2;
  localparam logic [20:0] LIMIT_RESET = 21'd256;

  localparam logic [7:0] SIN_DIV [SC_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
  localparam logic [7:0] COS_DIV [SC_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  localparam logic [63:0] RCP_ONE = 64'd4294967296;
  localparam logic [32:0] SIN_RCP [SC_STEPS] = '{
    33'(RCP_ONE / 64'd110), 33'(RCP_ONE / 64'd72), 33'(RCP_ONE / 64'd42),
    33'(RCP_ONE / 64'd20),  33'(RCP_ONE / 64'd6),  33'(RCP_ONE / 64'd1)};
  localparam logic [32:0] COS_RCP [SC_STEPS] = '{
    33'(RCP_ONE / 64'd132), 33'(RCP_ONE / 64'd90), 33'(RCP_ONE / 64'd56),
    33'(RCP_ONE / 64'd30),  33'(RCP_ONE / 64'd12), 33'(RCP_ONE / 64'd2)};

  typedef logic signed [71:0] wide_t;

  typedef struct packed {
    logic [2:0][31:0] t;
    logic [2:0][31:0] w;
    logic [31:0]      th;
    logic [34:0]      th30;
    logic             is_small;
    logic [31:0]      sn;
    logic [31:0]      cs;
    logic [31:0]      omc;
  } item_t;

  typedef struct packed {
    item_t       itm;
    logic [3:0]  k;
    logic        rneg;
    logic [29:0] ra;
    logic [30:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [30:0] ps;
    logic [30:0] pc;
    logic [31:0] qs;
    logic [31:0] qc;
  } sc_t;

  // unsigned Q30 product, rounded
  function automatic logic [30:0] mq(logic [30:0] a, logic [30:0] b);
    logic [61:0] pr;
    pr = {31'd0, a} * {31'd0, b} + (62'd1 << 29);
    return pr[60:30];
  endfunction

  function automatic logic [31:0] rcp_q(logic [30:0] p, logic [32:0] m);
    logic [63:0] pr;
    pr = {33'd0, p} * {31'd0, m};
    return pr[63:32];
  endfunction

  // finish the constant division and form one Horner term
  function automatic logic [30:0] series_t(logic [30:0] p, logic [31:0] q0, logic [7:0] d);
    logic [39:0] qd;
    logic [39:0] rem;
    logic [31:0] q;
    qd  = {8'd0, q0} * {32'd0, d};
    rem = {9'd0, p} - qd;
    q   = (rem >= {32'd0, d}) ? q0 + 32'd1 : q0;
    return ONE_Q30 - q[30:0];
  endfunction

  // rescale by 2^30, half away from zero
  function automatic wide_t rsh30(wide_t v);
    logic [71:0] m;
    m = v[71] ? 72'(-v) : 72'(v);
    m = (m + (72'd1 << 29)) >> 30;
    return v[71] ? -wide_t'(m) : wide_t'(m);
  endfunction

  function automatic logic [31:0] sat32(wide_t v);
    if (v > wide_t'(64'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (v < -wide_t'(64'sh8000_0000)) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/se3x_isqrt.sv @@
// ----------------------------------------------------------------------------
// se3x_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module se3x_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] s_in,
  output logic [31:0] root
);

  logic [63:0] rem [se3x_pkg::ISQ_STEPS+1];
  logic [63:0] res [se3x_pkg::ISQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= s_in;
      res[0] <= '0;
    end
  end

  genvar i;
  for (i = 1; i <= se3x_pkg::ISQ_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (i - 1));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[i-1] >= res[i-1] + BIT) begin
          rem[i] <= rem[i-1] - (res[i-1] + BIT);
          res[i] <= (res[i-1] >> 1) + BIT;
        end else begin
          rem[i] <= rem[i-1];
          res[i] <= res[i-1] >> 1;
        end
      end
    end
  end

  assign root = res[se3x_pkg::ISQ_STEPS][31:0];

endmodule

@@ hw/rtl/se3x_div.sv @@
// ----------------------------------------------------------------------------
// se3x_div
// Pipelined restoring divider, 31 quotient bits, with quotient overflow flag.
// ----------------------------------------------------------------------------
module se3x_div (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] num,
  input  logic [34:0] den,
  output logic [30:0] quo,
  output logic        ovf
);

  logic [61:0] rem [se3x_pkg::DIV_STEPS+1];
  logic [34:0] dv  [se3x_pkg::DIV_STEPS+1];
  logic [30:0] q   [se3x_pkg::DIV_STEPS+1];
  logic        of  [se3x_pkg::DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      q[0]   <= '0;
      of[0]  <= {4'd0, num} >= ({31'd0, den} << 31);
    end
  end

  genvar i;
  for (i = 1; i <= se3x_pkg::DIV_STEPS; i++) begin : g_step
    localparam int B = se3x_pkg::DIV_STEPS - i;
    logic [65:0] sh;
    assign sh = {31'd0, dv[i-1]} << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i] <= dv[i-1];
        of[i] <= of[i-1];
        if ({4'd0, rem[i-1]} >= sh) begin
          rem[i]  <= rem[i-1] - sh[61:0];
          q[i]    <= q[i-1] | (31'd1 << B);
        end else begin
          rem[i]  <= rem[i-1];
          q[i]    <= q[i-1];
        end
      end
    end
  end

  assign quo = q[se3x_pkg::DIV_STEPS];
  assign ovf = of[se3x_pkg::DIV_STEPS];

endmodule

@@ hw/rtl/se3_exponential_map_unit.sv @@
// ----------------------------------------------------------------------------
// se3_exponential_map_unit
// Twist to rigid transform: Rodrigues rotation and left-Jacobian translation.
// ----------------------------------------------------------------------------
// Fully pipelined: one twist per cycle while the output is not stalled. The
// path runs through the 32-stage square root, the 18-stage Taylor series for
// sin/cos and the dividers for the unit axis, sin/theta and (1-cos)/theta. A
// stalled output freezes the whole pipeline. Angles at or below
// small_angle_limit give the identity rotation and pass translation.
module se3_exponential_map_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] trans_x,
  input  logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] r00,
  output logic signed [31:0] r01,
  output logic signed [31:0] r02,
  output logic signed [31:0] r10,
  output logic signed [31:0] r11,
  output logic signed [31:0] r12,
  output logic signed [31:0] r20,
  output logic signed [31:0] r21,
  output logic signed [31:0] r22,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [20:0]        small_angle_limit
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic en;
  logic [20:0] limit;

  se3x_pkg::item_t p0, p1, p2, p4, p5, p7, p8;
  logic [2:0][63:0] sq;
  logic [63:0] sq_sum;
  logic [3:0] k4, k5, k7;
  logic rneg5, rneg7;
  logic [29:0] ra5;
  logic [30:0] smag7, tc7;
  logic v0, v1, v2, v4, v5, v7, v8;

  se3x_pkg::item_t isd [se3x_pkg::ISQ_LAT];
  logic [se3x_pkg::ISQ_LAT-1:0] isv;
  logic [31:0] th_root;

  se3x_pkg::sc_t sc [se3x_pkg::SC_N+1];
  logic [se3x_pkg::SC_N:0] scv;

  se3x_pkg::item_t dd [se3x_pkg::DIV_LAT];
  logic [se3x_pkg::DIV_LAT-1:0] ddv;
  logic [2:0][30:0] uq;
  logic [30:0] aq, dq;
  logic [2:0] uo;
  logic ao, dov;
  logic [2:0][61:0] unum;
  logic [61:0] anum, dnum;

  se3x_pkg::item_t q0i, q1i, q2i, q3i;
  logic signed [31:0] u0 [3], u1 [3], u2 [3];
  logic signed [31:0] a0, a1, a2, a3, d0, d1, d2;
  logic signed [31:0] uu [3][3];
  logic signed [63:0] ut [3][3];
  logic signed [39:0] m1 [3][3];
  logic signed [39:0] m2 [3][3];
  logic signed [39:0] dot2;
  logic signed [39:0] cr2 [3];
  logic [31:0] rot3 [3][3];
  logic signed [39:0] ud3 [3], at3 [3], dc3 [3];
  logic [31:0] rot4 [3][3];
  logic [31:0] pos4 [3];
  logic q0v, q1v, q2v, q3v, q4v;

  function automatic logic signed [31:0] hat(logic signed [31:0] u [3], int i, int j);
    logic signed [31:0] h;
    h = '0;
    if (i == 0 && j == 1) h = -u[2];
    if (i == 0 && j == 2) h = u[1];
    if (i == 1 && j == 0) h = u[2];
    if (i == 1 && j == 2) h = -u[0];
    if (i == 2 && j == 0) h = -u[1];
    if (i == 2 && j == 1) h = u[0];
    return h;
  endfunction

  assign en        = !q4v || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= se3x_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= small_angle_limit;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0;
      isv <= '0; scv <= '0; ddv <= '0;
      q0v <= 1'b0; q1v <= 1'b0; q2v <= 1'b0; q3v <= 1'b0; q4v <= 1'b0;
    end else if (en) begin
      v0  <= in_valid;
      v1  <= v0;
      v2  <= v1;
      isv <= {isv[se3x_pkg::ISQ_LAT-2:0], v2};
      v4  <= isv[se3x_pkg::ISQ_LAT-1];
      v5  <= v4;
      scv <= {scv[se3x_pkg::SC_N-1:0], v5};
      v7  <= scv[se3x_pkg::SC_N];
      v8  <= v7;
      ddv <= {ddv[se3x_pkg::DIV_LAT-2:0], v8};
      q0v <= ddv[se3x_pkg::DIV_LAT-1];
      q1v <= q0v;
      q2v <= q1v;
      q3v <= q2v;
      q4v <= q3v;
    end
  end

  // squares, sum of squares
  always_ff @(posedge clk) begin
    logic [31:0] mag;
    se3x_pkg::item_t nx;
    if (en) begin
      nx      = '0;
      nx.t[0] = trans_x; nx.t[1] = trans_y; nx.t[2] = trans_z;
      nx.w[0] = rot_x;   nx.w[1] = rot_y;   nx.w[2] = rot_z;
      p0 <= nx;
      p1 <= p0;
      for (int i = 0; i < 3; i++) begin
        mag   = p0.w[i][31] ? ~p0.w[i] + 32'd1 : p0.w[i];
        sq[i] <= {32'd0, mag} * {32'd0, mag};
      end
      p2     <= p1;
      sq_sum <= sq[0] + sq[1] + sq[2];
    end
  end

  se3x_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .s_in (sq_sum),
    .root (th_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      isd[0] <= p2;
      for (int i = 1; i < se3x_pkg::ISQ_LAT; i++) isd[i] <= isd[i-1];
    end
  end

  // angle, quadrant and residue
  always_ff @(posedge clk) begin
    logic [3:0]  kc;
    logic [35:0] kh;
    logic signed [36:0] r;
    se3x_pkg::item_t nx;
    if (en) begin
      nx          = isd[se3x_pkg::ISQ_LAT-1];
      nx.th       = th_root;
      nx.th30     = {th_root, 2'b00} + 35'd0;
      nx.is_small = th_root <= {11'd0, limit};
      p4 <= nx;
      kc = '0;
      for (int j = 1; j <= se3x_pkg::K_MAX; j++) begin
        if ({2'b00, th_root, 2'b00} >= 36'(j) * se3x_pkg::HALF_PI - se3x_pkg::HALF_PI_LOW)
          kc = kc + 4'd1;
      end
      k4 <= kc;

      p5 <= p4;
      k5 <= k4;
      kh = {32'd0, k4} * se3x_pkg::HALF_PI;
      r  = $signed({2'b00, p4.th30}) - $signed({1'b0, kh});
      rneg5 <= r[36];
      ra5   <= r[36] ? 30'(-r) : r[29:0];
    end
  end

  // sin/cos Horner series
  always_ff @(posedge clk) begin
    se3x_pkg::sc_t s0;
    if (en) begin
      s0      = '0;
      s0.itm  = p5;
      s0.k    = k5;
      s0.rneg = rneg5;
      s0.ra   = ra5;
      s0.x2   = se3x_pkg::mq({1'b0, ra5}, {1'b0, ra5});
      s0.ts   = se3x_pkg::ONE_Q30;
      s0.tc   = se3x_pkg::ONE_Q30;
      sc[0] <= s0;
    end
  end

  genvar g;
  for (g = 1; g <= se3x_pkg::SC_N; g++) begin : g_sc
    localparam int STEP = (g - 1) / 3;
    localparam int PH   = (g - 1) % 3;
    always_ff @(posedge clk) begin
      se3x_pkg::sc_t nx;
      if (en) begin
        nx = sc[g-1];
        if (PH == 0) begin
          nx.ps = se3x_pkg::mq(nx.x2, nx.ts);
          nx.pc = se3x_pkg::mq(nx.x2, nx.tc);
        end else if (PH == 1) begin
          nx.qs = se3x_pkg::rcp_q(nx.ps, se3x_pkg::SIN_RCP[STEP]);
          nx.qc = se3x_pkg::rcp_q(nx.pc, se3x_pkg::COS_RCP[STEP]);
        end else begin
          nx.tc = se3x_pkg::series_t(nx.pc, nx.qc, se3x_pkg::COS_DIV[STEP]);
          if (STEP < se3x_pkg::SIN_TERMS)
            nx.ts = se3x_pkg::series_t(nx.ps, nx.qs, se3x_pkg::SIN_DIV[STEP]);
        end
        sc[g] <= nx;
      end
    end
  end

  // quadrant mapping
  always_ff @(posedge clk) begin
    logic signed [31:0] s, c, sn, cs;
    se3x_pkg::item_t nx;
    if (en) begin
      p7    <= sc[se3x_pkg::SC_N].itm;
      k7    <= sc[se3x_pkg::SC_N].k;
      rneg7 <= sc[se3x_pkg::SC_N].rneg;
      tc7   <= sc[se3x_pkg::SC_N].tc;
      smag7 <= se3x_pkg::mq({1'b0, sc[se3x_pkg::SC_N].ra}, sc[se3x_pkg::SC_N].ts);

      s = rneg7 ? -$signed({1'b0, smag7}) : $signed({1'b0, smag7});
      c = $signed({1'b0, tc7});
      case (k7[1:0])
        QUAD_0:  begin sn = s;  cs = c;  end
        QUAD_1:  begin sn = c;  cs = -s; end
        QUAD_2:  begin sn = -s; cs = -c; end
        QUAD_3:  begin sn = -c; cs = s;  end
        default: begin sn = s;  cs = c;  end
      endcase
      nx     = p7;
      nx.sn  = sn;
      nx.cs  = cs;
      nx.omc = 32'(33'sd1073741824 - 33'(cs));
      p8 <= nx;
    end
  end

  // dividers: unit axis, sin/theta, (1-cos)/theta
  always_comb begin
    logic [31:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag     = p8.w[i][31] ? ~p8.w[i] + 32'd1 : p8.w[i];
      unum[i] = {mag, 30'd0};
    end
    mag  = p8.sn[31] ? ~p8.sn + 32'd1 : p8.sn;
    anum = {mag, 30'd0};
    dnum = {p8.omc, 30'd0};
  end

  for (g = 0; g < 3; g++) begin : g_udiv
    se3x_div u_div (
      .clk (clk),
      .en  (en),
      .num (unum[g]),
      .den ({3'd0, p8.th}),
      .quo (uq[g]),
      .ovf (uo[g])
    );
  end

  se3x_div u_adiv (
    .clk (clk), .en (en), .num (anum), .den (p8.th30), .quo (aq), .ovf (ao)
  );

  se3x_div u_ddiv (
    .clk (clk), .en (en), .num (dnum), .den (p8.th30), .quo (dq), .ovf (dov)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= p8;
      for (int i = 1; i < se3x_pkg::DIV_LAT; i++) dd[i] <= dd[i-1];
    end
  end

  // transform assembly
  always_ff @(posedge clk) begin
    logic [30:0] am, dm;
    logic signed [31:0] hu;
    se3x_pkg::wide_t pr, acc;
    if (en) begin
      q0i <= dd[se3x_pkg::DIV_LAT-1];
      for (int i = 0; i < 3; i++)
        u0[i] <= dd[se3x_pkg::DIV_LAT-1].w[i][31] ? -$signed({1'b0, uq[i]})
                                                  : $signed({1'b0, uq[i]});
      am = (ao || aq > se3x_pkg::ONE_Q30) ? se3x_pkg::ONE_Q30 : aq;
      dm = (dov || dq > se3x_pkg::ONE_Q30) ? se3x_pkg::ONE_Q30 : dq;
      a0 <= dd[se3x_pkg::DIV_LAT-1].sn[31] ? -$signed({1'b0, am}) : $signed({1'b0, am});
      d0 <= $signed({1'b0, dm});

      q1i <= q0i;
      a1  <= a0;
      d1  <= d0;
      for (int i = 0; i < 3; i++) begin
        u1[i] <= u0[i];
        for (int j = 0; j < 3; j++) begin
          pr       = u0[i] * u0[j];
          uu[i][j] <= 32'(se3x_pkg::rsh30(pr));
          ut[i][j] <= u0[i] * $signed(q0i.t[j]);
        end
      end

      q2i <= q1i;
      a2  <= a1;
      d2  <= d1;
      for (int i = 0; i < 3; i++) begin
        u2[i] <= u1[i];
        for (int j = 0; j < 3; j++) begin
          pr       = $signed({1'b0, q1i.omc}) * uu[i][j];
          m1[i][j] <= 40'(se3x_pkg::rsh30(pr));
          hu       = hat(u1, i, j);
          pr       = $signed(q1i.sn) * hu;
          m2[i][j] <= 40'(se3x_pkg::rsh30(pr));
        end
      end
      acc  = se3x_pkg::wide_t'(ut[0][0]) + ut[1][1] + ut[2][2];
      dot2 <= 40'(se3x_pkg::rsh30(acc));
      acc  = se3x_pkg::wide_t'(ut[1][2]) - ut[2][1];
      cr2[0] <= 40'(se3x_pkg::rsh30(acc));
      acc  = se3x_pkg::wide_t'(ut[2][0]) - ut[0][2];
      cr2[1] <= 40'(se3x_pkg::rsh30(acc));
      acc  = se3x_pkg::wide_t'(ut[0][1]) - ut[1][0];
      cr2[2] <= 40'(se3x_pkg::rsh30(acc));

      q3i <= q2i;
      a3  <= a2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = se3x_pkg::wide_t'(m1[i][j]) + m2[i][j];
          if (i == j) acc = acc + $signed(q2i.cs);
          rot3[i][j] <= se3x_pkg::sat32(acc);
        end
        pr      = u2[i] * dot2;
        ud3[i]  <= 40'(se3x_pkg::rsh30(pr));
        pr      = a2 * $signed(q2i.t[i]);
        at3[i]  <= 40'(se3x_pkg::rsh30(pr));
        pr      = d2 * cr2[i];
        dc3[i]  <= 40'(se3x_pkg::rsh30(pr));
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (q3i.is_small) rot4[i][j] <= (i == j) ? {1'b0, se3x_pkg::ONE_Q30} : 32'd0;
          else              rot4[i][j] <= rot3[i][j];
        end
        pr  = (33'sd1073741824 - 33'(a3)) * ud3[i];
        acc = se3x_pkg::wide_t'(at3[i]) + se3x_pkg::rsh30(pr) + dc3[i];
        pos4[i] <= q3i.is_small ? q3i.t[i] : se3x_pkg::sat32(acc);
      end
    end
  end

  assign out_valid = q4v;
  assign r00   = rot4[0][0];
  assign r01   = rot4[0][1];
  assign r02   = rot4[0][2];
  assign r10   = rot4[1][0];
  assign r11   = rot4[1][1];
  assign r12   = rot4[1][2];
  assign r20   = rot4[2][0];
  assign r21   = rot4[2][1];
  assign r22   = rot4[2][2];
  assign out_x = pos4[0];
  assign out_y = pos4[1];
  assign out_z = pos4[2];

endmodule

@@ hw/rtl/se3x_checker.sv @@
// ----------------------------------------------------------------------------
// se3x_checker
// Port-level checks of the exponential map unit, bound to the top level.
// ----------------------------------------------------------------------------
module se3x_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] r00,
  input logic signed [31:0] out_x,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r00) && $stable(out_x))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline frozen");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config transaction refused");

endmodule

bind se3_exponential_map_unit se3x_checker u_se3x_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .r00       (r00),
  .out_x     (out_x),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

@@ tb/tb_se3_exponential_map_unit.sv @@
// ----------------------------------------------------------------------------
// tb_se3_exponential_map_unit
// Self-checking bench for the SE(3) exponential map. A directed table covers
// small-angle cutoffs, zero and full-scale twists and translation saturation.
// Random twists follow, spread over several small_angle_limit settings. Every
// result transaction is checked field by field; identity rows carry their
// answer, others use a fixed-point Rodrigues and left-Jacobian model.
// ----------------------------------------------------------------------------
module tb_se3_exponential_map_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE        = 64'sd1 << 30;
  localparam longint HPI        = 64'sd1686629713;
  localparam int     LAT_CYC    = 110;
  localparam int     STALL_MAX  = 2000;
  localparam int     N_RANDOM   = 1830;
  localparam logic [20:0] LIM_MAX  = 21'd1048576;
  localparam logic [20:0] LIM_OVER = 21'h1FFFFF;

  typedef struct packed {
    logic [2:0][31:0] t;
    logic [2:0][31:0] w;
  } twist_t;

  typedef struct packed {
    logic [8:0][31:0] rm;
    logic [2:0][31:0] p;
  } xform_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [31:0] trans_x, trans_y, trans_z, rot_x, rot_y, rot_z;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [31:0] out_x, out_y, out_z;
  logic [20:0] small_angle_limit;

  se3_exponential_map_unit DUT (.*);

  logic [20:0] angle_limit;
  xform_t      expected_xforms[$];
  int          errors;
  int          idle_cycles;
  bit          rx_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round30(longint v);
    if (v >= 0) return (v + (64'sd1 << 29)) >>> 30;
    return -((-v + (64'sd1 << 29)) >>> 30);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic xform_t exp_map(twist_t tw, logic [20:0] lim);
    int          sdiv[5] = '{110, 72, 42, 20, 6};
    int          cdiv[6] = '{132, 90, 56, 30, 12, 2};
    xform_t      x;
    longint      t[3], w[3], u[3], hat[3][3], cr[3];
    longint      th, th30, k, r, s, c, sn, cs, a, d, omc, dot, v;
    logic [63:0] sq, ra, x2, acc, mag;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = longint'($signed(tw.t[i]));
      w[i] = longint'($signed(tw.w[i]));
      mag  = w[i] < 0 ? -w[i] : w[i];
      sq   = sq + mag * mag;
    end
    th = longint'(root64(sq));
    if (th <= longint'(lim)) begin
      for (int i = 0; i < 9; i++) x.rm[i] = (i % 4 == 0) ? 32'h4000_0000 : 32'h0;
      for (int i = 0; i < 3; i++) x.p[i] = tw.t[i];
      return x;
    end
    th30 = th * 4;
    for (int i = 0; i < 3; i++) u[i] = w[i] * ONE / th;
    k  = (th30 + HPI / 2) / HPI;
    r  = th30 - k * HPI;
    ra = r < 0 ? -r : r;
    x2 = q30_mul(ra, ra);
    acc = ONE;
    for (int i = 0; i < 5; i++) acc = ONE - q30_mul(x2, acc) / sdiv[i];
    s = longint'(q30_mul(ra, acc));
    if (r < 0) s = -s;
    acc = ONE;
    for (int i = 0; i < 6; i++) acc = ONE - q30_mul(x2, acc) / cdiv[i];
    c = longint'(acc);
    case (k & 3)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    a   = clamp_one(sn * ONE / th30);
    d   = clamp_one((ONE - cs) * ONE / th30);
    omc = ONE - cs;
    hat = '{'{0, -u[2], u[1]}, '{u[2], 0, -u[0]}, '{-u[1], u[0], 0}};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = (i == j ? cs : 0) + round30(omc * round30(u[i] * u[j]))
            + round30(sn * hat[i][j]);
        x.rm[i * 3 + j] = 32'(sat32(v));
      end
    dot   = round30(u[0] * t[0] + u[1] * t[1] + u[2] * t[2]);
    cr[0] = round30(u[1] * t[2] - u[2] * t[1]);
    cr[1] = round30(u[2] * t[0] - u[0] * t[2]);
    cr[2] = round30(u[0] * t[1] - u[1] * t[0]);
    for (int i = 0; i < 3; i++) begin
      v = round30(a * t[i]) + round30((ONE - a) * round30(u[i] * dot))
          + round30(d * cr[i]);
      x.p[i] = 32'(sat32(v));
    end
    return x;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, field,
             $signed(got), $signed(want));
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    xform_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.rm = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
      got.p  = {out_z, out_y, out_x};
      if (expected_xforms.size() == 0) begin
        $display("[%0t] result transaction with nothing expected", $time);
        errors++;
      end else begin
        want = expected_xforms.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.rm[i] !== want.rm[i])
            report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), got.rm[i], want.rm[i]);
        for (int i = 0; i < 3; i++)
          if (got.p[i] !== want.p[i])
            report_mismatch($sformatf("out_%0d", i), got.p[i], want.p[i]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_twist(twist_t tw, bit quiet, bit typed, xform_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {trans_z, trans_y, trans_x} <= tw.t;
    {rot_z, rot_y, rot_x}       <= tw.w;
    do @(posedge clk); while (!in_ready);
    expected_xforms.push_back(typed ? want : exp_map(tw, angle_limit));
  endtask

  task automatic write_limit(logic [20:0] value);
    in_valid <= 1'b0;
    while (expected_xforms.size() != 0) @(posedge clk);
    repeat (LAT_CYC) @(posedge clk);
    cfg_valid         <= 1'b1;
    small_angle_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    angle_limit = value;
  endtask

  function automatic logic [31:0] rand_rot();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 600)) - 300);
      1: return $urandom;
      2: return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
      default: return 32'($signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_trans();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
  endfunction

  twist_t directed_twists[18] = '{
    '{t: '{32'h0, 32'h0, 32'h0},                      w: '{32'h0, 32'h0, 32'h0}},
    '{t: '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}, w: '{32'h0, 32'h0, 32'h0}},
    '{t: '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000}, w: '{32'h0, 32'h0, 32'd256}},
    '{t: '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, w: '{32'h0, -32'sd256, 32'h0}},
    '{t: '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, w: '{32'd147, 32'd147, 32'd147}},
    '{t: '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, w: '{32'h0, 32'h0, 32'd257}},
    '{t: '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000}, w: '{32'd257, 32'h0, 32'h0}},
    '{t: '{32'h0010_0000, 32'h0, 32'h0},              w: '{32'h0, 32'h1000_0000, 32'h0}},
    '{t: '{32'h0, 32'h0010_0000, 32'h0},              w: '{32'h0, 32'h0, 32'h3243_F6A9}},
    '{t: '{32'h0, 32'h0, 32'h0010_0000},              w: '{32'h1921_FB54, 32'h0, 32'h0}},
    '{t: '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, w: '{32'h3243_F6A9, 32'h0, 32'h0}},
    '{t: '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, w: '{32'h0, 32'hC000_0000, 32'h0}},
    '{t: '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
      w: '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
    '{t: '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
      w: '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}},
    '{t: '{32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F},
      w: '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0}},
    '{t: '{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555},
      w: '{32'h0000_0001, 32'hFFFF_FFFF, 32'h6487_ED51}},
    '{t: '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000},
      w: '{32'h0C90_FDAA, 32'hF36F_0256, 32'h0C90_FDAA}},
    '{t: '{32'h0000_FFFF, 32'hFFFF_0001, 32'h7FFF_0000},
      w: '{32'h4000_0000, 32'h4000_0000, 32'h0}}
  };
  bit directed_typed[18] = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  initial begin
    twist_t tw;
    xform_t want;
    logic [20:0] limits[4];
    rst               = 1'b1;
    in_valid          = 1'b0;
    cfg_valid         = 1'b0;
    small_angle_limit = se3x_pkg::LIMIT_RESET;
    {trans_z, trans_y, trans_x, rot_z, rot_y, rot_x} = '0;
    angle_limit = se3x_pkg::LIMIT_RESET;
    errors      = 0;
    idle_cycles = 0;
    rx_burst    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset limit; identity rows carry their answer
    foreach (directed_twists[i]) begin
      tw = directed_twists[i];
      for (int j = 0; j < 9; j++) want.rm[j] = (j % 4 == 0) ? 32'h4000_0000 : 32'h0;
      want.p = tw.t;
      send_twist(tw, 1'b0, directed_typed[i], want);
    end

    limits = '{21'd0, LIM_MAX, LIM_OVER, 21'($urandom_range(0, 2097151))};
    foreach (limits[ph]) begin
      write_limit(limits[ph]);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        if (n % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        tw.t = {rand_trans(), rand_trans(), rand_trans()};
        tw.w = {rand_rot(), rand_rot(), rand_rot()};
        send_twist(tw, rx_burst, 1'b0, want);
      end
    end
    write_limit(se3x_pkg::LIMIT_RESET);
    for (int n = 0; n < 20; n++) begin
      tw.t = {rand_trans(), rand_trans(), rand_trans()};
      tw.w = {rand_rot(), rand_rot(), rand_rot()};
      send_twist(tw, 1'b0, 1'b0, want);
    end
    in_valid <= 1'b0;

    while (expected_xforms.size() != 0) @(posedge clk);
    repeat (LAT_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
